// File: src/rhsv_pkg.sv
package rhsv_pkg;

    // Field and datapath widths.
    localparam int PIX_W      = 8;
    localparam int NUM_W      = 16;
    localparam int HDEN_W     = 11;
    localparam int SQ_W       = 8;
    localparam int HQ_W       = 6;
    localparam int HUE_W      = 10;

    // One quotient bit per divider stage, plus the min/max stage, the
    // scaling stage and the output stage.
    localparam int DIV_STAGES = SQ_W;
    localparam int NUM_STAGES = DIV_STAGES + 3;
    localparam int LAST_STAGE = NUM_STAGES - 1;

    // Hue circle constants.
    localparam int FULL_SCALE = 255;
    localparam int HUE_OFS_G  = 85;
    localparam int HUE_OFS_B  = 170;

    // Which channel holds the maximum; red wins ties over green, green over blue.
    typedef enum logic [1:0] {
        SECT_RED   = 2'd0,
        SECT_GREEN = 2'd1,
        SECT_BLUE  = 2'd2
    } sect_t;

    // Payload carried through the divider stages.
    typedef struct packed {
        sect_t              sect;
        logic               gray;
        logic               hneg;
        logic [PIX_W-1:0]   bright;
        logic [NUM_W-1:0]   srem;
        logic [PIX_W-1:0]   sden;
        logic [SQ_W-1:0]    squo;
        logic [NUM_W-1:0]   hrem;
        logic [HDEN_W-1:0]  hden;
        logic [HQ_W-1:0]    hquo;
    } div_t;

    // One restoring division step for quotient bit bitpos of both dividers.
    // The hue quotient only has its low HQ_W bits.
    function automatic div_t div_step(input div_t x, input int bitpos);
        logic [NUM_W:0] s_trial;
        logic [NUM_W:0] h_trial;
        div_t           y;
        y       = x;
        s_trial = (NUM_W + 1)'(x.sden) << bitpos;
        h_trial = (NUM_W + 1)'(x.hden) << bitpos;
        if ({1'b0, x.srem} >= s_trial)
        begin
            y.srem = x.srem - s_trial[NUM_W-1:0];
            y.squo = x.squo | (SQ_W'(1) << bitpos);
        end
        if (bitpos < HQ_W)
        begin
            if ({1'b0, x.hrem} >= h_trial)
            begin
                y.hrem = x.hrem - h_trial[NUM_W-1:0];
                y.hquo = x.hquo | (HQ_W'(1) << bitpos);
            end
        end
        return y;
    endfunction

endpackage

// File: src/rgb_to_hsv_converter_top.sv
// RGB to HSV converter, 8 bits per channel.
// Pixels arrive as beats on the pix channel (red, green, blue with
// pix_valid / pix_ready) and leave as beats on the hsv channel (hue,
// saturation, brightness with hsv_valid / hsv_ready). Brightness is the
// largest channel, saturation the rounded delta*255/max and hue a point on
// a 255-step circle with red at 0; a grey pixel gives zero hue and
// saturation.
// An accepted pixel passes through every stage register in turn, from the
// min/max stage to the output register, before its beat is offered.
// Throughput is one pixel per clock while hsv_ready is high: the two
// divisions run as an 8-stage restoring divider, one quotient bit per stage,
// so the saturation quotient width sets the depth of the pipeline.
// Every stage has its own valid bit and loads whenever it is empty or the
// stage after it moves, so bubbles are squeezed out. When the receiver
// stalls, the output register holds its beat and the stages behind it keep
// filling; pix_ready drops only once all 11 stages hold a pixel.
// Reset clears the valid bits only; the pipeline is empty afterwards and
// no output beat is produced until a pixel has been accepted.
module rgb_to_hsv_converter_top
    import rhsv_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             pix_valid,
    output logic             pix_ready,
    input  logic [PIX_W-1:0] red,
    input  logic [PIX_W-1:0] green,
    input  logic [PIX_W-1:0] blue,
    output logic             hsv_valid,
    input  logic             hsv_ready,
    output logic [PIX_W-1:0] hue,
    output logic [PIX_W-1:0] saturation,
    output logic [PIX_W-1:0] brightness
);

    logic [NUM_STAGES-1:0] valid_reg;
    logic [NUM_STAGES-1:0] valid_next;
    logic [NUM_STAGES-1:0] stage_en;

    // Stage 0 registers: extremes and the two operands of the hue difference.
    logic [PIX_W-1:0] mx_reg, mx_next;
    logic [PIX_W-1:0] mn_reg, mn_next;
    logic [PIX_W-1:0] opa_reg, opa_next;
    logic [PIX_W-1:0] opb_reg, opb_next;
    sect_t            sect_reg, sect_next;

    // Divider pipeline: entry 0 is loaded by the scaling stage.
    div_t div_reg  [DIV_STAGES+1];
    div_t div_next [DIV_STAGES+1];

    // Scaling stage intermediates.
    logic [PIX_W-1:0] delta;
    logic [PIX_W:0]   diff;
    logic [PIX_W-1:0] diff_mag;

    // Output stage intermediates.
    div_t                    dl;
    logic [SQ_W:0]           sat_sum;
    logic [HQ_W:0]           hq;
    logic signed [HUE_W-1:0] hue_s;
    logic signed [HUE_W-1:0] hue_w;

    logic [PIX_W-1:0] hue_reg, hue_next;
    logic [PIX_W-1:0] sat_reg, sat_next;
    logic [PIX_W-1:0] bright_reg, bright_next;

    // Handshake: a stage loads when it is empty or its successor moves on.
    always_comb
    begin
        stage_en[LAST_STAGE] = !valid_reg[LAST_STAGE] || hsv_ready;
        for (int i = LAST_STAGE - 1; i >= 0; i--)
        begin
            stage_en[i] = !valid_reg[i] || stage_en[i + 1];
        end
        valid_next[0] = stage_en[0] ? pix_valid : valid_reg[0];
        for (int i = 1; i < NUM_STAGES; i++)
        begin
            valid_next[i] = stage_en[i] ? valid_reg[i - 1] : valid_reg[i];
        end
    end

    assign pix_ready  = stage_en[0];
    assign hsv_valid  = valid_reg[LAST_STAGE];
    assign hue        = hue_reg;
    assign saturation = sat_reg;
    assign brightness = bright_reg;

    // Stage 0: maximum, minimum and the sector of the maximum.
    always_comb
    begin
        mx_next = red;
        if (green > mx_next)
        begin
            mx_next = green;
        end
        if (blue > mx_next)
        begin
            mx_next = blue;
        end
        mn_next = red;
        if (green < mn_next)
        begin
            mn_next = green;
        end
        if (blue < mn_next)
        begin
            mn_next = blue;
        end
        if (red == mx_next)
        begin
            sect_next = SECT_RED;
            opa_next  = green;
            opb_next  = blue;
        end
        else if (green == mx_next)
        begin
            sect_next = SECT_GREEN;
            opa_next  = blue;
            opb_next  = red;
        end
        else
        begin
            sect_next = SECT_BLUE;
            opa_next  = red;
            opb_next  = green;
        end
    end

    // Stage 1: delta, hue difference as sign and magnitude, numerators times 255.
    always_comb
    begin
        delta    = mx_reg - mn_reg;
        diff     = {1'b0, opa_reg} - {1'b0, opb_reg};
        diff_mag = diff[PIX_W] ? PIX_W'(-diff) : diff[PIX_W-1:0];

        div_next[0].sect   = sect_reg;
        div_next[0].gray   = (delta == '0);
        div_next[0].hneg   = diff[PIX_W];
        div_next[0].bright = mx_reg;
        div_next[0].srem   = {delta, {PIX_W{1'b0}}} - NUM_W'(delta);
        div_next[0].sden   = mx_reg;
        div_next[0].squo   = '0;
        div_next[0].hrem   = {diff_mag, {PIX_W{1'b0}}} - NUM_W'(diff_mag);
        div_next[0].hden   = (HDEN_W'(delta) << 2) + (HDEN_W'(delta) << 1);
        div_next[0].hquo   = '0;

        // Divider stages, most significant quotient bit first.
        for (int k = 0; k < DIV_STAGES; k++)
        begin
            div_next[k + 1] = div_step(div_reg[k], DIV_STAGES - 1 - k);
        end
    end

    // Output stage: rounding, saturation clamp, hue offset and wrap.
    always_comb
    begin
        dl      = div_reg[DIV_STAGES];
        sat_sum = {1'b0, dl.squo}
                + (SQ_W + 1)'(dl.srem >= NUM_W'(dl.sden >> 1));
        hq      = {1'b0, dl.hquo}
                + (HQ_W + 1)'(!dl.hneg && (dl.hrem >= NUM_W'(dl.hden >> 1)));
        hue_s   = dl.hneg ? -signed'(HUE_W'(hq)) : signed'(HUE_W'(hq));
        case (dl.sect)
            SECT_RED:   hue_w = hue_s;
            SECT_GREEN: hue_w = hue_s + HUE_W'(HUE_OFS_G);
            SECT_BLUE:  hue_w = hue_s + HUE_W'(HUE_OFS_B);
            default:    hue_w = hue_s;
        endcase
        if (hue_w < 0)
        begin
            hue_w = hue_w + HUE_W'(FULL_SCALE);
        end
        else if (hue_w > HUE_W'(FULL_SCALE))
        begin
            hue_w = hue_w - HUE_W'(FULL_SCALE);
        end

        bright_next = dl.bright;
        if (dl.gray)
        begin
            hue_next = '0;
            sat_next = '0;
        end
        else
        begin
            hue_next = hue_w[PIX_W-1:0];
            sat_next = sat_sum[SQ_W] ? PIX_W'(FULL_SCALE) : sat_sum[SQ_W-1:0];
        end
    end

    // Valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Payload registers, loaded together with their valid bit.
    always_ff @(posedge clk)
    begin
        if (stage_en[0] && pix_valid)
        begin
            mx_reg   <= mx_next;
            mn_reg   <= mn_next;
            opa_reg  <= opa_next;
            opb_reg  <= opb_next;
            sect_reg <= sect_next;
        end
        for (int k = 0; k <= DIV_STAGES; k++)
        begin
            if (stage_en[k + 1] && valid_reg[k])
            begin
                div_reg[k] <= div_next[k];
            end
        end
        if (stage_en[LAST_STAGE] && valid_reg[LAST_STAGE - 1])
        begin
            hue_reg    <= hue_next;
            sat_reg    <= sat_next;
            bright_reg <= bright_next;
        end
    end

    // An empty output register means the whole pipeline can take a beat.
    a_ready_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
        !valid_reg[LAST_STAGE] |-> pix_ready)
        else $error("pix_ready low although the output register is empty");

    // Saturation is zero only for a grey pixel, which also has zero hue.
    a_grey_hue: assert property (@(posedge clk) disable iff (!rst_n)
        (hsv_valid && (saturation == '0)) |-> (hue == '0))
        else $error("zero saturation with non-zero hue");

    // A black pixel is grey.
    a_black: assert property (@(posedge clk) disable iff (!rst_n)
        (hsv_valid && (brightness == '0)) |-> (saturation == '0))
        else $error("black pixel with non-zero saturation");

    // The divider leaves remainders below their divisors.
    a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg[LAST_STAGE - 1] && !div_reg[DIV_STAGES].gray)
        |-> ((div_reg[DIV_STAGES].srem < NUM_W'(div_reg[DIV_STAGES].sden))
          && (div_reg[DIV_STAGES].hrem < NUM_W'(div_reg[DIV_STAGES].hden))))
        else $error("divider remainder not below divisor");

endmodule
